>>> sv/http_request_line_parser_defines.svh
// Assertion macros used by the HTTP request line parser RTL.
`ifndef HTTP_REQUEST_LINE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define HRLP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define HRLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/hrlp_pkg.sv
// Shared types, codes and character constants of the HTTP request line parser.
package hrlp_pkg;

   localparam int MAX_REQUEST_BYTES_DEF = 4096;
   localparam int QUEUE_DEPTH_DEF       = 4;

   localparam int DATA_W   = 8;
   localparam int KIND_W   = 3;
   localparam int OFFSET_W = 12;
   localparam int LENGTH_W = 13;
   localparam int VCODE_W  = 2;
   localparam int STATUS_W = 2;
   localparam int STOP_W   = 13;

   localparam logic [KIND_W-1:0] KIND_METHOD  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_URL     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VERSION = 3'd2;
   localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END     = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_FINISHED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [VCODE_W-1:0] VER_INVALID = 2'd0;
   localparam logic [VCODE_W-1:0] VER_11      = 2'd1;
   localparam logic [VCODE_W-1:0] VER_10      = 2'd2;

   localparam logic METHOD_INVALID = 1'b0;
   localparam logic METHOD_GET     = 1'b1;

   localparam logic [DATA_W-1:0] CH_NUL = 8'h00;
   localparam logic [DATA_W-1:0] CH_LF  = 8'h0a;
   localparam logic [DATA_W-1:0] CH_CR  = 8'h0d;
   localparam logic [DATA_W-1:0] CH_SP  = 8'h20;

   localparam int GET_LEN = 3;
   localparam int VER_LEN = 8;

   localparam logic [DATA_W-1:0] GET_TEXT [GET_LEN] = '{8'h47, 8'h45, 8'h54};
   // "HTTP/1.1"; the 1.0 form differs only in its last byte
   localparam logic [DATA_W-1:0] VER11_TEXT [VER_LEN] =
      '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e, 8'h31};
   localparam logic [DATA_W-1:0] VER10_LAST = 8'h30;

   typedef enum logic [4:0] {
      PH_METHOD    = 5'b00001,
      PH_URL       = 5'b00010,
      PH_VERSION   = 5'b00100,
      PH_HEADER    = 5'b01000,
      PH_HEADER_NL = 5'b10000
   } phase_type;

   typedef struct packed {
      logic                is_end;
      logic                is_sp;
      logic                is_lf;
      logic                is_cr;
      logic [GET_LEN-1:0]  get_eq;
      logic [VER_LEN-1:0]  ver11_eq;
      logic                ver10_last_eq;
   } byte_class_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

>>> sv/hrlp_req_if.sv
// Request byte channel: valid/ready handshake with one byte or end marker.
interface hrlp_req_if;
   import hrlp_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              end_of_data;

   modport source (output valid, output data_byte, output end_of_data, input ready);
   modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

>>> sv/hrlp_rsp_if.sv
// Result channel: valid/ready handshake carrying one piece or end result.
interface hrlp_rsp_if;
   import hrlp_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   piece_kind;
   logic [OFFSET_W-1:0] piece_offset;
   logic [LENGTH_W-1:0] piece_length;
   logic                method_code;
   logic [VCODE_W-1:0]  version_code;
   logic [STATUS_W-1:0] end_status;
   logic [STOP_W-1:0]   stop_position;

   modport source (output valid, output piece_kind, output piece_offset,
                   output piece_length, output method_code, output version_code,
                   output end_status, output stop_position, input ready);
   modport sink   (input valid, input piece_kind, input piece_offset,
                   input piece_length, input method_code, input version_code,
                   input end_status, input stop_position, output ready);
endinterface

>>> sv/http_request_line_parser.sv
// An accepted byte is stored in the queue, then taken by the parser core, whose result is registered.
// Throughput: one byte per cycle; the parser core handles one queued byte each cycle
// while the result register is free or being taken.
// Queue depth QUEUE_DEPTH absorbs result-side stalls before req ready drops.
// Reset (synchronous, active high) empties the queue and result register and
// puts the parser in the method phase at byte position zero.
`include "http_request_line_parser_defines.svh"

module http_request_line_parser
   import hrlp_pkg::*;
#(
   parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF,
   parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
)(
   input  logic       clock,
   input  logic       reset,
   hrlp_req_if.sink   req_chan,
   hrlp_rsp_if.source rsp_chan
);

   queue_stat_type q_stat;
   logic           q_push;
   logic           q_pop;
   byte_class_type q_push_item;
   byte_class_type q_pop_item;

   hrlp_front u_front (
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_item   (q_push_item)
   );

   hrlp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .q_stat    (q_stat)
   );

   hrlp_back #(
      .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!q_stat.empty),
      .item       (q_pop_item),
      .item_pop   (q_pop),
      .rsp_chan   (rsp_chan)
   );

   `HRLP_ASSERT_IMP(a_pop_not_empty, q_pop, !q_stat.empty, "pop from empty queue")
   `HRLP_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "queue lost an entry")
   `HRLP_ASSERT_IMP(a_end_no_piece, rsp_chan.valid && rsp_chan.piece_kind == KIND_END,
      rsp_chan.piece_offset == '0 && rsp_chan.piece_length == '0, "end result has piece")
   `HRLP_ASSERT_IMP(a_piece_no_codes, rsp_chan.valid && rsp_chan.piece_kind != KIND_END,
      rsp_chan.end_status == STATUS_FINISHED && rsp_chan.stop_position == '0,
      "piece result has end fields")

endmodule

>>> sv/hrlp_front.sv
// Front end: accepts request bytes and classifies them for the parser core.
module hrlp_front
   import hrlp_pkg::*;
(
   hrlp_req_if.sink       req_chan,
   input  queue_stat_type q_stat,
   output logic           q_push,
   output byte_class_type q_item
);

   assign req_chan.ready = !q_stat.full;
   assign q_push         = req_chan.valid && req_chan.ready;

   always_comb begin
      q_item.is_end = req_chan.end_of_data || (req_chan.data_byte == CH_NUL);
      q_item.is_sp  = (req_chan.data_byte == CH_SP);
      q_item.is_lf  = (req_chan.data_byte == CH_LF);
      q_item.is_cr  = (req_chan.data_byte == CH_CR);
      for (int i = 0; i < GET_LEN; i++) begin
         q_item.get_eq[i] = (req_chan.data_byte == GET_TEXT[i]);
      end
      for (int i = 0; i < VER_LEN; i++) begin
         q_item.ver11_eq[i] = (req_chan.data_byte == VER11_TEXT[i]);
      end
      q_item.ver10_last_eq = (req_chan.data_byte == VER10_LAST);
   end

endmodule

>>> sv/hrlp_queue.sv
// Short FIFO of classified bytes between the front end and the parser core.
module hrlp_queue
   import hrlp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  byte_class_type push_item,
   input  logic           pop,
   output byte_class_type pop_item,
   output queue_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   byte_class_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

>>> sv/hrlp_back.sv
// Parser core: phase machine, piece bookkeeping, matching and result register.
module hrlp_back
   import hrlp_pkg::*;
#(
   parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   input  byte_class_type item,
   output logic           item_pop,
   hrlp_rsp_if.source     rsp_chan
);

   localparam int POS_W = $clog2(MAX_REQUEST_BYTES + 1);

   phase_type            phase_ff, phase_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     start_ff, start_in;
   logic [POS_W-1:0]     count_ff, count_in;
   logic                 meth_ok_ff, meth_ok_in;
   logic                 meth_code_ff, meth_code_in;
   logic [1:0]           vflags_ff, vflags_in;
   logic [VCODE_W-1:0]   vcode_ff, vcode_in;
   logic [3:0]           vraw_ff, vraw_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;
   logic [LENGTH_W-1:0]  length_ff, length_in;
   logic                 mcode_ff, mcode_in;
   logic [VCODE_W-1:0]   vout_ff, vout_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [STOP_W-1:0]    stop_ff, stop_in;

   logic                 emit;
   logic                 do_end;
   logic [POS_W-1:0]     pos_inc;
   logic                 mism11, mism10;
   logic [1:0]           vflags_upd;

   assign item_pop = item_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pos_inc  = pos_ff + 1'b1;

   always_comb begin
      mism11 = !item.ver11_eq[vraw_ff[2:0]];
      mism10 = (vraw_ff[2:0] == 3'(VER_LEN - 1)) ? !item.ver10_last_eq : mism11;
      vflags_upd = vflags_ff;
      if (!vraw_ff[3]) begin
         if (mism11) vflags_upd[0] = 1'b0;
         if (mism10) vflags_upd[1] = 1'b0;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      meth_ok_in   = meth_ok_ff;
      meth_code_in = meth_code_ff;
      vflags_in    = vflags_ff;
      vcode_in     = vcode_ff;
      vraw_in      = vraw_ff;
      emit         = 1'b0;
      do_end       = 1'b0;
      kind_in      = KIND_METHOD;
      status_in    = STATUS_FINISHED;

      if (item.is_end) begin
         do_end    = 1'b1;
         status_in = (pos_ff == '0) ? STATUS_EMPTY : STATUS_FINISHED;
      end else if (pos_ff >= POS_W'(MAX_REQUEST_BYTES)) begin
         do_end    = 1'b1;
         status_in = STATUS_OVERFLOW;
      end else begin
         case (phase_ff)
            PH_METHOD: begin
               if (item.is_sp) begin
                  meth_code_in = (meth_ok_ff && count_ff == POS_W'(GET_LEN)) ?
                                 METHOD_GET : METHOD_INVALID;
                  emit         = 1'b1;
                  kind_in      = KIND_METHOD;
                  phase_in     = PH_URL;
               end else begin
                  if (count_ff >= POS_W'(GET_LEN) || !item.get_eq[count_ff[1:0]]) begin
                     meth_ok_in = 1'b0;
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            PH_URL: begin
               if (item.is_sp) begin
                  emit     = 1'b1;
                  kind_in  = KIND_URL;
                  phase_in = PH_VERSION;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PH_VERSION: begin
               vflags_in = vflags_upd;
               if (item.is_lf) begin
                  if (count_ff == POS_W'(VER_LEN) && vflags_upd[0]) begin
                     vcode_in = VER_11;
                  end else if (count_ff == POS_W'(VER_LEN) && vflags_upd[1]) begin
                     vcode_in = VER_10;
                  end else begin
                     vcode_in = VER_INVALID;
                  end
                  emit     = 1'b1;
                  kind_in  = KIND_VERSION;
                  phase_in = PH_HEADER;
               end else begin
                  // raw index counts CR bytes too; saturate past the text
                  if (!vraw_ff[3]) vraw_in = vraw_ff + 1'b1;
                  if (!item.is_cr) count_in = count_ff + 1'b1;
               end
            end
            PH_HEADER: begin
               if (item.is_lf) begin
                  emit     = 1'b1;
                  kind_in  = KIND_HEADER;
                  phase_in = PH_HEADER_NL;
               end else if (!item.is_cr) begin
                  count_in = count_ff + 1'b1;
               end
            end
            PH_HEADER_NL: begin
               if (item.is_lf) begin
                  do_end    = 1'b1;
                  status_in = STATUS_FINISHED;
               end else if (!item.is_cr) begin
                  phase_in = PH_HEADER;
                  count_in = count_ff + 1'b1;
               end
            end
            default: begin
               phase_in = PH_METHOD;
            end
         endcase
         if (emit) begin
            start_in = pos_inc;
            count_in = '0;
            vraw_in  = '0;
         end
         pos_in = pos_inc;
      end

      // piece results carry no codes; the end result carries no piece
      offset_in = '0;
      length_in = '0;
      mcode_in  = METHOD_INVALID;
      vout_in   = VER_INVALID;
      stop_in   = '0;
      if (do_end) begin
         kind_in  = KIND_END;
         mcode_in = meth_code_ff;
         vout_in  = vcode_ff;
         stop_in  = STOP_W'(pos_ff);
         // restart the request with the next byte
         phase_in     = PH_METHOD;
         pos_in       = '0;
         start_in     = '0;
         count_in     = '0;
         meth_ok_in   = 1'b1;
         meth_code_in = METHOD_INVALID;
         vflags_in    = 2'b11;
         vcode_in     = VER_INVALID;
         vraw_in      = '0;
      end else begin
         status_in = STATUS_FINISHED;
         offset_in = OFFSET_W'(start_ff);
         length_in = LENGTH_W'(count_ff);
      end

      if (item_pop && (emit || do_end)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_METHOD;
         pos_ff       <= '0;
         start_ff     <= '0;
         count_ff     <= '0;
         meth_ok_ff   <= 1'b1;
         meth_code_ff <= METHOD_INVALID;
         vflags_ff    <= 2'b11;
         vcode_ff     <= VER_INVALID;
         vraw_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            phase_ff     <= phase_in;
            pos_ff       <= pos_in;
            start_ff     <= start_in;
            count_ff     <= count_in;
            meth_ok_ff   <= meth_ok_in;
            meth_code_ff <= meth_code_in;
            vflags_ff    <= vflags_in;
            vcode_ff     <= vcode_in;
            vraw_ff      <= vraw_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && (emit || do_end)) begin
         kind_ff   <= kind_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         mcode_ff  <= mcode_in;
         vout_ff   <= vout_in;
         status_ff <= status_in;
         stop_ff   <= stop_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.piece_kind    = kind_ff;
   assign rsp_chan.piece_offset  = offset_ff;
   assign rsp_chan.piece_length  = length_ff;
   assign rsp_chan.method_code   = mcode_ff;
   assign rsp_chan.version_code  = vout_ff;
   assign rsp_chan.end_status    = status_ff;
   assign rsp_chan.stop_position = stop_ff;

endmodule
